// ----- rtl/ir_burst_duration_capture_top_defines.svh -----
// assertion macros for the ir burst capture rtl
`ifndef IR_BURST_DURATION_CAPTURE_TOP_DEFINES_SVH
`define IR_BURST_DURATION_CAPTURE_TOP_DEFINES_SVH

// condition holds at every clock edge outside reset
`define IRBDC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define IRBDC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define IRBDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/irbdc_pkg.sv -----
// types, constants and helpers for the ir burst duration capture block
package irbdc_pkg;

    // pair store depth and counter width
    localparam int MAX_PAIRS = 128;
    localparam int PAIR_W    = $clog2(MAX_PAIRS + 1);

    // tick counter width and saturation value
    localparam int TICK_W = 24;
    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

    // configuration register indexes
    localparam logic [1:0] CFG_MERGE_GAP = 2'd0;
    localparam logic [1:0] CFG_US_TICK   = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT   = 2'd2;

    // register reset values
    localparam logic [15:0]       MERGE_GAP_RST = 16'd10;
    localparam logic [7:0]        US_TICK_RST   = 8'd1;
    localparam logic [TICK_W-1:0] TIMEOUT_RST   = 24'd1000000;

    // capture phase
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_WAIT  = 2'd1,
        PH_PULSE = 2'd2,
        PH_GAP   = 2'd3
    } phase_t;

    // result status codes
    typedef enum logic [1:0] {
        STAT_PAIR    = 2'd0,
        STAT_TIMEOUT = 2'd1,
        STAT_FULL    = 2'd2
    } status_t;

    // scale ticks to microseconds, saturated at 16 bits
    function automatic logic [15:0] ticks_to_us(input logic [TICK_W-1:0] ticks,
                                                input logic [7:0] scale);
        logic [TICK_W+7:0] prod;
        prod = {8'd0, ticks} * {{TICK_W{1'b0}}, scale};
        return (prod[TICK_W+7:16] != '0) ? 16'hFFFF : prod[15:0];
    endfunction

endpackage

// ----- rtl/ir_burst_duration_capture_top.sv -----
// Samples a raw IR line, merges carrier gaps into bursts and reports pulse/space
// pairs in microseconds. One line sample is taken per clock cycle, back to back,
// while the result register is empty or being read: a sample is held in an input
// register, and the whole state update (phase, saturating tick counters, merge
// compare and the two 24x8 scaling multipliers) is combinational logic into the
// result register. A begin request restarts capture, a timeout or a full pair
// store (MAX_PAIRS pairs) ends it; idle samples are ignored.
`include "ir_burst_duration_capture_top_defines.svh"

module ir_burst_duration_capture_top (
    input  logic        aclk,
    input  logic        aresetn,
    // line sample input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] begin_req, [1] line_active, rest zero
    // pair result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] pulse_us, [31:16] space_us
    output logic [1:0]  m_tuser,   // [1:0] status
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    import irbdc_pkg::*;

    // configuration registers
    logic [15:0]       merge_gap_reg;
    logic [7:0]        us_tick_reg;
    logic [TICK_W-1:0] timeout_reg;

    // input stage
    logic in_vld_reg;
    logic begin_reg;
    logic active_reg;

    // capture state
    phase_t            phase_reg, phase_next;
    logic [TICK_W-1:0] burst_reg, burst_next;
    logic [TICK_W-1:0] gap_reg, gap_next;
    logic [TICK_W-1:0] wait_reg, wait_next;
    logic [PAIR_W-1:0] pairs_reg, pairs_next;

    // result stage
    logic        out_vld_reg;
    logic [15:0] pulse_reg;
    logic [15:0] space_reg;
    status_t     status_reg;

    // working values after a possible restart
    phase_t            ph_w;
    logic [TICK_W-1:0] burst_w, gap_w, wait_w;
    logic [PAIR_W-1:0] pairs_w;
    logic [TICK_W:0]   merge_sum;
    logic              gap_merges;
    logic              store_room;

    // result of this cycle's sample
    logic        res_vld;
    logic [15:0] res_pulse;
    logic [15:0] res_space;
    status_t     res_status;

    logic proc;
    logic out_free;

    // handshake
    assign out_free  = !out_vld_reg || m_tready;
    assign proc      = in_vld_reg && out_free;
    assign s_tready  = !in_vld_reg || proc;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {space_reg, pulse_reg};
    assign m_tuser  = status_reg;

    // configuration write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            merge_gap_reg <= MERGE_GAP_RST;
            us_tick_reg   <= US_TICK_RST;
            timeout_reg   <= TIMEOUT_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_MERGE_GAP: merge_gap_reg <= cfg_data[15:0];
                CFG_US_TICK:   us_tick_reg   <= cfg_data[7:0];
                CFG_TIMEOUT:   timeout_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            begin_reg  <= s_tdata[0];
            active_reg <= s_tdata[1];
        end
    end

    // restart view of the state
    always_comb begin
        ph_w    = begin_reg ? PH_WAIT : phase_reg;
        burst_w = begin_reg ? '0 : burst_reg;
        gap_w   = begin_reg ? '0 : gap_reg;
        wait_w  = begin_reg ? timeout_reg : wait_reg;
        pairs_w = begin_reg ? '0 : pairs_reg;
    end

    assign merge_sum  = {1'b0, burst_w} + {1'b0, gap_w};
    assign gap_merges = gap_w <= {{(TICK_W-16){1'b0}}, merge_gap_reg};
    assign store_room = pairs_w < PAIR_W'(MAX_PAIRS);

    // next state
    always_comb begin
        phase_next = ph_w;
        burst_next = burst_w;
        gap_next   = gap_w;
        wait_next  = wait_w;
        pairs_next = pairs_w;
        unique case (ph_w)
            PH_WAIT: begin
                if (active_reg) begin
                    burst_next = TICK_W'(1);
                    gap_next   = '0;
                    phase_next = PH_PULSE;
                end else if (wait_w == '0) begin
                    phase_next = PH_IDLE;
                end else begin
                    wait_next = wait_w - TICK_W'(1);
                end
            end
            PH_PULSE: begin
                if (active_reg) begin
                    burst_next = (burst_w == TICK_MAX) ? TICK_MAX : burst_w + TICK_W'(1);
                end else begin
                    gap_next   = TICK_W'(1);
                    phase_next = PH_GAP;
                end
            end
            PH_GAP: begin
                if (!active_reg) begin
                    gap_next = (gap_w == TICK_MAX) ? TICK_MAX : gap_w + TICK_W'(1);
                end else if (gap_merges) begin
                    // carrier gap folds into the burst
                    burst_next = (merge_sum >= {1'b0, TICK_MAX}) ? TICK_MAX
                               : merge_sum[TICK_W-1:0] + TICK_W'(1);
                    gap_next   = '0;
                    phase_next = PH_PULSE;
                end else if (store_room) begin
                    pairs_next = pairs_w + PAIR_W'(1);
                    burst_next = TICK_W'(1);
                    gap_next   = '0;
                    phase_next = PH_PULSE;
                end else begin
                    phase_next = PH_IDLE;
                end
            end
            default: ;
        endcase
    end

    // result decode
    always_comb begin
        res_vld    = 1'b0;
        res_pulse  = '0;
        res_space  = '0;
        res_status = STAT_PAIR;
        unique case (ph_w)
            PH_WAIT: begin
                if (!active_reg && wait_w == '0) begin
                    res_vld    = 1'b1;
                    res_status = STAT_TIMEOUT;
                end
            end
            PH_GAP: begin
                if (active_reg && !gap_merges) begin
                    res_vld = 1'b1;
                    if (store_room) begin
                        res_pulse = ticks_to_us(burst_w, us_tick_reg);
                        res_space = ticks_to_us(gap_w, us_tick_reg);
                    end else begin
                        res_status = STAT_FULL;
                    end
                end
            end
            default: ;
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            burst_reg <= '0;
            gap_reg   <= '0;
            wait_reg  <= '0;
            pairs_reg <= '0;
        end else if (proc) begin
            phase_reg <= phase_next;
            burst_reg <= burst_next;
            gap_reg   <= gap_next;
            wait_reg  <= wait_next;
            pairs_reg <= pairs_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (proc) begin
            out_vld_reg <= res_vld;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc && res_vld) begin
            pulse_reg  <= res_pulse;
            space_reg  <= res_space;
            status_reg <= res_status;
        end
    end

    // checks
    `IRBDC_ASSERT_SAME(a_status_zero_fields, m_tvalid && (m_tuser != STAT_PAIR), m_tdata == '0, "timeout or full result carries durations")
    `IRBDC_ASSERT_ALWAYS(a_pairs_bound, pairs_reg <= PAIR_W'(MAX_PAIRS), "pair count above store depth")
    `IRBDC_ASSERT_NEXT(a_end_goes_idle, proc && res_vld && (res_status != STAT_PAIR), phase_reg == PH_IDLE, "capture did not stop after end status")
    `IRBDC_ASSERT_SAME(a_gap_nonzero, phase_reg == PH_GAP, gap_reg != '0, "gap phase with empty gap count")
    `IRBDC_ASSERT_SAME(a_burst_nonzero, (phase_reg == PH_PULSE) || (phase_reg == PH_GAP), burst_reg != '0, "burst phase with empty burst count")

endmodule

// ----- bench/ir_burst_duration_capture_checker.sv -----
// scoreboard for the ir burst capture block: predicts pair reports and checks the result stream
`timescale 1ns / 1ps

module ir_burst_duration_capture_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] begin_req, [1] line_active
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [15:0] pulse_us, [31:16] space_us
    input  logic [1:0]  m_tuser,   // [1:0] status
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    output int          errors,
    output int          outstanding,
    output int          pair_reports,
    output int          timeout_reports,
    output int          full_reports
);
    import irbdc_pkg::*;

    typedef struct packed {
        logic [15:0] pulse_us;
        logic [15:0] space_us;
        status_t     status;
    } capture_report_t;

    // shadow copy of the configuration registers
    logic [15:0]       merge_gap;
    logic [7:0]        us_tick;
    logic [TICK_W-1:0] timeout_lim;

    // shadow copy of the capture state
    phase_t            cap_phase;
    logic [TICK_W-1:0] burst_len;
    logic [TICK_W-1:0] gap_len;
    logic [TICK_W-1:0] wait_left;
    int                pairs_stored;

    capture_report_t   expected_reports[$];
    capture_report_t   oldest;

    // saturating tick counter add
    function automatic logic [TICK_W-1:0] tick_add(input logic [TICK_W-1:0] a,
                                                   input logic [TICK_W-1:0] b);
        logic [TICK_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[TICK_W] ? TICK_MAX : sum[TICK_W-1:0];
    endfunction

    // ticks to microseconds with the current scale, clipped to 16 bits
    function automatic logic [15:0] ticks_in_us(input logic [TICK_W-1:0] ticks);
        logic [31:0] prod;
        prod = {8'd0, ticks} * {24'd0, us_tick};
        return (prod > 32'hFFFF) ? 16'hFFFF : prod[15:0];
    endfunction

    // one line sample through the capture state, queueing any report it causes
    task automatic advance_capture(input bit beg, input bit act);
        if (beg) begin
            pairs_stored = 0;
            wait_left    = timeout_lim;
            burst_len    = '0;
            gap_len      = '0;
            cap_phase    = PH_WAIT;
        end
        case (cap_phase)
            PH_WAIT: begin
                if (act) begin
                    burst_len = 24'd1;
                    gap_len   = '0;
                    cap_phase = PH_PULSE;
                end else if (wait_left == '0) begin
                    cap_phase = PH_IDLE;
                    expected_reports.push_back('{16'd0, 16'd0, STAT_TIMEOUT});
                end else begin
                    wait_left = wait_left - 24'd1;
                end
            end
            PH_PULSE: begin
                if (act) begin
                    burst_len = tick_add(burst_len, 24'd1);
                end else begin
                    gap_len   = 24'd1;
                    cap_phase = PH_GAP;
                end
            end
            PH_GAP: begin
                if (!act) begin
                    gap_len = tick_add(gap_len, 24'd1);
                end else if (gap_len <= {8'd0, merge_gap}) begin
                    // short gap is carrier: fold it into the burst
                    burst_len = tick_add(tick_add(burst_len, gap_len), 24'd1);
                    gap_len   = '0;
                    cap_phase = PH_PULSE;
                end else if (pairs_stored < MAX_PAIRS) begin
                    expected_reports.push_back('{ticks_in_us(burst_len),
                                                 ticks_in_us(gap_len), STAT_PAIR});
                    pairs_stored++;
                    burst_len = 24'd1;
                    gap_len   = '0;
                    cap_phase = PH_PULSE;
                end else begin
                    cap_phase = PH_IDLE;
                    expected_reports.push_back('{16'd0, 16'd0, STAT_FULL});
                end
            end
            default: ;
        endcase
    endtask

    // watch all three channels at the rising edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            merge_gap    = MERGE_GAP_RST;
            us_tick      = US_TICK_RST;
            timeout_lim  = TIMEOUT_RST;
            cap_phase    = PH_IDLE;
            burst_len    = '0;
            gap_len      = '0;
            wait_left    = '0;
            pairs_stored = 0;
            expected_reports.delete();
        end else begin
            // register write transfer
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_MERGE_GAP: merge_gap   = cfg_data[15:0];
                    CFG_US_TICK:   us_tick     = cfg_data[7:0];
                    CFG_TIMEOUT:   timeout_lim = cfg_data;
                    default: ;
                endcase
            end
            // line sample transfer
            if (s_tvalid && s_tready)
                advance_capture(s_tdata[0], s_tdata[1]);
            // result transfer
            if (m_tvalid && m_tready) begin
                if (expected_reports.size() == 0) begin
                    $error("unexpected result: pulse_us %0d space_us %0d status %0d",
                           m_tdata[15:0], m_tdata[31:16], m_tuser);
                    errors++;
                end else begin
                    oldest = expected_reports.pop_front();
                    if (m_tdata[15:0] !== oldest.pulse_us) begin
                        $error("pulse_us mismatch: expected %0d, actual %0d",
                               oldest.pulse_us, m_tdata[15:0]);
                        errors++;
                    end
                    if (m_tdata[31:16] !== oldest.space_us) begin
                        $error("space_us mismatch: expected %0d, actual %0d",
                               oldest.space_us, m_tdata[31:16]);
                        errors++;
                    end
                    if (m_tuser !== oldest.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               oldest.status, m_tuser);
                        errors++;
                    end
                end
                case (m_tuser)
                    STAT_PAIR:    pair_reports++;
                    STAT_TIMEOUT: timeout_reports++;
                    STAT_FULL:    full_reports++;
                    default: ;
                endcase
            end
        end
        outstanding = expected_reports.size();
    end

endmodule

// ----- bench/ir_burst_duration_capture_top_tb.sv -----
// stimulus, handshake pacing and verdict for the ir burst capture block
`timescale 1ns / 1ps

module ir_burst_duration_capture_top_tb;
    import irbdc_pkg::*;

    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 3000;
    localparam int SETTLE      = 4;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [0] begin_req, [1] line_active, rest zero
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [15:0] pulse_us, [31:16] space_us
    logic [1:0]  m_tuser;   // [1:0] status
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [23:0] cfg_data;

    int check_errors;
    int check_outstanding;
    int pair_reports;
    int timeout_reports;
    int full_reports;

    int          samples_sent;
    bit          calm;
    int          hold_asked;
    int          hold_served;
    int          hold_left;
    int          stall_cycles;
    logic [15:0] cur_merge;
    logic [23:0] cur_timeout;

    ir_burst_duration_capture_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ir_burst_duration_capture_checker capture_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .errors          (check_errors),
        .outstanding     (check_outstanding),
        .pair_reports    (pair_reports),
        .timeout_reports (timeout_reports),
        .full_reports    (full_reports)
    );

    // 10 ns clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // result side pacing, with a long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_asked != hold_served) begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(99) >= 17);
            end
        end
    end

    // stall watchdog: too long with no transfer on any channel
    initial begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    // offer one line sample and wait for its transfer
    task automatic offer_sample(input bit beg, input bit act);
        @(negedge aclk);
        if (!calm) begin
            while ($urandom_range(99) < 17) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, act, beg};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        samples_sent++;
    endtask

    // stop offering, let every expected report arrive and the pipeline empty
    task automatic settle_block();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (check_outstanding != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // carrier burst: active stretches split by gaps short enough to merge
    task automatic send_burst();
        int segs;
        segs = $urandom_range(1, 4);
        if ($urandom_range(99) < 3) begin
            repeat ($urandom_range(250, 300)) offer_sample(1'b0, 1'b1);
        end else begin
            for (int k = 0; k < segs; k++) begin
                repeat ($urandom_range(1, 6)) offer_sample(1'b0, 1'b1);
                if (k < segs - 1 && cur_merge != 0)
                    repeat ($urandom_range(1, (cur_merge < 4) ? cur_merge : 4))
                        offer_sample(1'b0, 1'b0);
            end
        end
    endtask

    // space that closes the pair while the merge limit is below 40, sometimes long enough to clip
    task automatic send_space();
        if ($urandom_range(99) < 3 && cur_merge < 250)
            repeat ($urandom_range(250, 300)) offer_sample(1'b0, 1'b0);
        else if (cur_merge < 40)
            repeat (cur_merge + 1 + $urandom_range(0, 5)) offer_sample(1'b0, 1'b0);
        else
            repeat ($urandom_range(1, 8)) offer_sample(1'b0, 1'b0);
    endtask

    // well-formed capture: begin, short wait, then a train of pulse/space pairs
    task automatic capture_run(input int pairs);
        offer_sample(1'b1, 1'($urandom_range(1)));
        repeat ($urandom_range(0, 3)) offer_sample(1'b0, 1'b0);
        repeat (pairs) begin
            send_burst();
            send_space();
        end
        offer_sample(1'b0, 1'b1);
    endtask

    // begin and sit inactive, around the timeout boundary when the timeout is below 40
    task automatic timeout_run();
        offer_sample(1'b1, 1'b0);
        if (cur_timeout < 40)
            repeat (cur_timeout + $urandom_range(0, 2)) offer_sample(1'b0, 1'b0);
        else
            repeat ($urandom_range(0, 5)) offer_sample(1'b0, 1'b0);
        offer_sample(1'b0, 1'($urandom_range(1)));
    endtask

    task automatic noise_run();
        repeat ($urandom_range(5, 20))
            offer_sample($urandom_range(99) < 5, 1'($urandom_range(1)));
    endtask

    // with no merging every two samples close a pair, overrunning the store
    task automatic fill_pair_store();
        offer_sample(1'b1, 1'b1);
        repeat (MAX_PAIRS + 3) begin
            offer_sample(1'b0, 1'b0);
            offer_sample(1'b0, 1'b1);
        end
    endtask

    task automatic run_phase(input logic [15:0] merge, input logic [7:0] scale,
                             input logic [23:0] tmo, input int quota,
                             input bit calm_half, input bit fill_store);
        int stop_at;
        int half_at;
        int pick;
        settle_block();
        write_reg(CFG_MERGE_GAP, {8'd0, merge});
        write_reg(CFG_US_TICK, {16'd0, scale});
        write_reg(CFG_TIMEOUT, tmo);
        cur_merge   = merge;
        cur_timeout = tmo;
        stop_at     = samples_sent + quota;
        half_at     = samples_sent + quota / 2;
        calm        = calm_half;
        if (fill_store) begin
            hold_asked++;
            fill_pair_store();
        end
        while (samples_sent < stop_at) begin
            if (samples_sent >= half_at)
                calm = 1'b0;
            pick = $urandom_range(99);
            if (pick < 70)
                capture_run($urandom_range(1, 6));
            else if (pick < 82)
                timeout_run();
            else
                noise_run();
        end
        calm = 1'b0;
    endtask

    // main stimulus
    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_MERGE_GAP;
        cfg_data     = '0;
        samples_sent = 0;
        calm         = 1'b0;
        hold_asked   = 0;
        hold_served  = 0;
        hold_left    = 0;
        cur_merge    = MERGE_GAP_RST;
        cur_timeout  = TIMEOUT_RST;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: merge up to 2 ticks, maximum scale, timeout after 3 samples
        write_reg(CFG_MERGE_GAP, 24'd2);
        write_reg(CFG_US_TICK, 24'd255);
        write_reg(CFG_TIMEOUT, 24'd2);
        cur_merge   = 16'd2;
        cur_timeout = 24'd2;
        // sample while idle is ignored
        offer_sample(1'b0, 1'b1);
        // no activity: timeout on the third inactive sample
        offer_sample(1'b1, 1'b0);
        offer_sample(1'b0, 1'b0);
        offer_sample(1'b0, 1'b0);
        // begin together with an active sample
        offer_sample(1'b1, 1'b1);
        // gap equal to the merge limit is folded in
        offer_sample(1'b0, 1'b0);
        offer_sample(1'b0, 1'b0);
        offer_sample(1'b0, 1'b1);
        // gap one past the limit closes a pair
        offer_sample(1'b0, 1'b0);
        offer_sample(1'b0, 1'b0);
        offer_sample(1'b0, 1'b0);
        offer_sample(1'b0, 1'b1);
        // restart in the middle of a burst and of a gap
        offer_sample(1'b1, 1'b0);
        offer_sample(1'b0, 1'b1);
        offer_sample(1'b0, 1'b0);
        offer_sample(1'b1, 1'b1);
        offer_sample(1'b0, 1'b1);

        // random phases across the register extremes
        run_phase(16'd0,     8'd1,   24'd0,        450, 1'b0, 1'b1);
        run_phase(16'd65535, 8'd255, 24'hFFFFFF,   150, 1'b0, 1'b0);
        run_phase(16'd3,     8'd7,   24'd20,       350, 1'b1, 1'b0);
        run_phase(16'd10,    8'd255, 24'd5,        300, 1'b0, 1'b0);
        run_phase(16'd1,     8'd1,   24'd2,        300, 1'b0, 1'b0);

        // drain and let the pipeline run dry
        settle_block();
        repeat (8) @(negedge aclk);

        $display("tb run: %0d line samples; reports seen: %0d pairs, %0d timeouts, %0d store full",
                 samples_sent, pair_reports, timeout_reports, full_reports);
        $display("tb run: merge gap 0..65535, scale 1..255 us/tick, timeout 0..16777215 ticks");
        if (check_errors == 0 && check_outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
